### hw/rtl/ctok_pkg.sv
`default_nettype none

package ctok_pkg;

   // Identifier and string tokens close once their text reaches this length.
   localparam logic [7:0] MAX_TEXT = 8'd127;

   // Result queue between the lexer and the result port.
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = RSP_PTR_W + 1;

   localparam logic [1:0] KIND_TEXT  = 2'd0;
   localparam logic [1:0] KIND_TOKEN = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;
   localparam logic [1:0] KIND_END   = 2'd3;

   localparam logic [4:0] TOK_ID          = 5'd0;
   localparam logic [4:0] TOK_CONST       = 5'd1;
   localparam logic [4:0] TOK_STRING      = 5'd2;
   localparam logic [4:0] TOK_KW_BASE     = 5'd3;
   localparam logic [4:0] TOK_LE          = 5'd11;
   localparam logic [4:0] TOK_GE          = 5'd12;
   localparam logic [4:0] TOK_NE          = 5'd13;
   localparam logic [4:0] TOK_EQ          = 5'd14;
   localparam logic [4:0] TOK_OROR        = 5'd15;
   localparam logic [4:0] TOK_ANDAND      = 5'd16;
   localparam logic [4:0] TOK_NONE        = 5'd0;

   localparam logic [2:0] ERR_BAD_CHAR       = 3'd0;
   localparam logic [2:0] ERR_BAD_PUNCT      = 3'd1;
   localparam logic [2:0] ERR_BAD_CHR_ESC    = 3'd2;
   localparam logic [2:0] ERR_MISSING_QUOTE  = 3'd3;
   localparam logic [2:0] ERR_BAD_STR_ESC    = 3'd4;
   localparam logic [2:0] ERR_NONE           = 3'd0;

   // Keywords in token order; each word is right aligned, first char highest.
   localparam logic [47:0] KW_WORD [8] = '{
      48'("int"), 48'("char"), 48'("if"), 48'("else"),
      48'("for"), 48'("while"), 48'("return"), 48'("sizeof")
   };
   localparam logic [2:0] KW_LEN [8] = '{3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd5, 3'd6, 3'd6};

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_HASH,
      MODE_ID,
      MODE_NUM,
      MODE_OP,
      MODE_STR,
      MODE_STR_ESC,
      MODE_CHR,
      MODE_CHR_ESC,
      MODE_CHR_END
   } mode_type;

   typedef struct packed {
      logic [7:0] byte_req;
      logic       at_end;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [4:0]  token;
      logic [31:0] value;
      logic [2:0]  error_code;
      logic        last;
   } rsp_type;

   // Up to two results written into the queue in one cycle.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    beat0;
      rsp_type    beat1;
   } rsp_push_type;

   // What a byte does when it is lexed from the idle mode.
   typedef struct packed {
      mode_type   mode;
      logic       emit;
      rsp_type    res;
      logic [7:0] mask;
   } idle_type;

   function automatic rsp_type mk_res(logic [1:0] kind, logic [4:0] tok,
                                      logic [31:0] val, logic [2:0] err);
      rsp_type r;
      r.kind       = kind;
      r.token      = tok;
      r.value      = val;
      r.error_code = err;
      r.last       = 1'b0;
      return r;
   endfunction

   function automatic logic is_alpha(logic [7:0] b);
      return (b inside {["a":"z"], ["A":"Z"]});
   endfunction

   function automatic logic is_digit(logic [7:0] b);
      return (b inside {["0":"9"]});
   endfunction

   function automatic logic is_id_char(logic [7:0] b);
      return is_alpha(b) || is_digit(b) || (b == "_");
   endfunction

   // Keywords that are long enough and hold byte b at position pos.
   function automatic logic [7:0] kw_match(logic [7:0] pos, logic [7:0] b);
      logic [7:0] m;
      logic [2:0] sh;
      m = '0;
      for (int k = 0; k < 8; k++) begin
         sh = KW_LEN[k] - 3'd1 - pos[2:0];
         if (pos < {5'd0, KW_LEN[k]} && KW_WORD[k][{sh, 3'd0} +: 8] == b) begin
            m[k] = 1'b1;
         end
      end
      return m;
   endfunction

   // Token code of a closed identifier: the first surviving keyword of matching length.
   function automatic logic [4:0] kw_code(logic [7:0] mask, logic [7:0] len);
      logic [4:0] code;
      code = TOK_ID;
      for (int k = 7; k >= 0; k--) begin
         if (mask[k] && {5'd0, KW_LEN[k]} == len) begin
            code = TOK_KW_BASE + 5'(k);
         end
      end
      return code;
   endfunction

   function automatic logic [4:0] single_code(logic [7:0] b);
      logic [4:0] code;
      case (b)
         ";":     code = 5'd17;
         "(":     code = 5'd18;
         ")":     code = 5'd19;
         "{":     code = 5'd20;
         "}":     code = 5'd21;
         "-":     code = 5'd22;
         "+":     code = 5'd23;
         "*":     code = 5'd24;
         ",":     code = 5'd25;
         "<":     code = 5'd26;
         ">":     code = 5'd27;
         "!":     code = 5'd28;
         "=":     code = 5'd29;
         "|":     code = 5'd30;
         "&":     code = 5'd31;
         default: code = TOK_NONE;
      endcase
      return code;
   endfunction

   function automatic logic [4:0] double_code(logic [7:0] p, logic [7:0] b);
      logic [4:0] code;
      code = TOK_NONE;
      if (b == "=") begin
         case (p)
            "<":     code = TOK_LE;
            ">":     code = TOK_GE;
            "!":     code = TOK_NE;
            "=":     code = TOK_EQ;
            default: code = TOK_NONE;
         endcase
      end else if (b == "|" && p == "|") begin
         code = TOK_OROR;
      end else if (b == "&" && p == "&") begin
         code = TOK_ANDAND;
      end
      return code;
   endfunction

   function automatic idle_type idle_step(logic [7:0] b);
      idle_type r;
      r.mode = MODE_IDLE;
      r.emit = 1'b0;
      r.res  = mk_res(KIND_TEXT, TOK_ID, {24'd0, b}, ERR_NONE);
      r.mask = kw_match(8'd0, b);
      if (b inside {[8'd9:8'd13], " "}) begin
         r.mode = MODE_IDLE;
      end else if (is_alpha(b) || b == "_") begin
         r.mode = MODE_ID;
         r.emit = 1'b1;
      end else if (is_digit(b)) begin
         r.mode = MODE_NUM;
      end else if (b == "'") begin
         r.mode = MODE_CHR;
      end else if (b == "\"") begin
         r.mode = MODE_STR;
      end else if (b == "#") begin
         r.mode = MODE_HASH;
      end else if (b inside {"<", ">", "!", "=", "|", "&"}) begin
         r.mode = MODE_OP;
      end else if (single_code(b) != TOK_NONE) begin
         r.emit = 1'b1;
         r.res  = mk_res(KIND_TOKEN, single_code(b), 32'd0, ERR_NONE);
      end else if (b inside {[8'd33:8'd126]}) begin
         r.emit = 1'b1;
         r.res  = mk_res(KIND_ERROR, TOK_NONE, 32'd0, ERR_BAD_PUNCT);
      end else begin
         r.emit = 1'b1;
         r.res  = mk_res(KIND_ERROR, TOK_NONE, 32'd0, ERR_BAD_CHAR);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/c_subset_tokenizer.sv
`default_nettype none
// A result is written into the result queue when its source beat is accepted. The
// four-entry queue takes a beat while it has room for two more results. Throughput:
// one source beat per cycle while the queue has room; a beat that closes a token and
// starts another gives two results; the port drains one result per cycle on rsp_ready.
// Reset (synchronous, active high) empties the queue and returns the lexer to idle.

module c_subset_tokenizer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire ctok_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output ctok_pkg::rsp_type      rsp_payload
);
   import ctok_pkg::*;

   rsp_push_type push;
   logic         room;
   logic         accept;

   assign req_ready = room;
   assign accept    = req_valid && room;

   ctok_lexer u_lexer (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_payload (req_payload),
      .push        (push)
   );

   ctok_rsp_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .room        (room),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

### hw/rtl/ctok_lexer.sv
`default_nettype none

module ctok_lexer (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire ctok_pkg::req_type     req_payload,
   output ctok_pkg::rsp_push_type     push
);
   import ctok_pkg::*;

   mode_type    mode_ff, mode_in;
   logic [7:0]  text_length_ff, text_length_in;
   logic [7:0]  keyword_mask_ff, keyword_mask_in;
   logic [31:0] number_acc_ff, number_acc_in;
   logic [7:0]  pending_op_ff, pending_op_in;
   logic [7:0]  char_value_ff, char_value_in;

   logic [7:0]  b;
   idle_type    idle;
   logic [7:0]  id_mask_upd;
   logic [7:0]  tl_inc;
   logic        tl_full;
   logic [31:0] acc_mul;
   logic [4:0]  dbl_code;
   logic [7:0]  esc_val;
   logic        str_esc_ok;
   logic        chr_esc_ok;
   logic        take_idle;
   rsp_type     res0, res1;
   logic [1:0]  n_res;

   assign b           = req_payload.byte_req;
   assign idle        = idle_step(b);
   assign id_mask_upd = keyword_mask_ff & kw_match(text_length_ff, b);
   assign tl_inc      = text_length_ff + 8'd1;
   assign tl_full     = (tl_inc >= MAX_TEXT);
   assign acc_mul     = (number_acc_ff << 3) + (number_acc_ff << 1) + {24'd0, b - 8'h30};
   assign dbl_code    = double_code(pending_op_ff, b);
   assign str_esc_ok  = (b inside {"n", "t", "\\", "\""});
   assign chr_esc_ok  = (b inside {"n", "t", "\\", "'"});

   always_comb begin
      case (b)
         "n":     esc_val = 8'h0A;
         "t":     esc_val = 8'h09;
         default: esc_val = b;
      endcase
   end

   // Next state.
   always_comb begin
      mode_in         = mode_ff;
      text_length_in  = text_length_ff;
      keyword_mask_in = keyword_mask_ff;
      number_acc_in   = number_acc_ff;
      pending_op_in   = pending_op_ff;
      char_value_in   = char_value_ff;
      take_idle       = 1'b0;
      if (accept) begin
         if (req_payload.at_end) begin
            mode_in = MODE_IDLE;
         end else begin
            case (mode_ff)
               MODE_HASH: begin
                  if (b == 8'h0A) mode_in = MODE_IDLE;
               end
               MODE_ID: begin
                  if (is_id_char(b)) begin
                     keyword_mask_in = id_mask_upd;
                     text_length_in  = tl_inc;
                     if (tl_full) mode_in = MODE_IDLE;
                  end else begin
                     take_idle = 1'b1;
                  end
               end
               MODE_NUM: begin
                  if (is_digit(b)) number_acc_in = acc_mul;
                  else take_idle = 1'b1;
               end
               MODE_OP: begin
                  if (dbl_code != TOK_NONE) mode_in = MODE_IDLE;
                  else take_idle = 1'b1;
               end
               MODE_STR: begin
                  if (b == "\"") begin
                     mode_in = MODE_IDLE;
                  end else if (b == "\\") begin
                     mode_in = MODE_STR_ESC;
                  end else begin
                     text_length_in = tl_inc;
                     if (tl_full) mode_in = MODE_IDLE;
                  end
               end
               MODE_STR_ESC: begin
                  if (str_esc_ok) begin
                     text_length_in = tl_inc;
                     mode_in        = tl_full ? MODE_IDLE : MODE_STR;
                  end else begin
                     mode_in = MODE_IDLE;
                  end
               end
               MODE_CHR: begin
                  if (b == "\\") begin
                     mode_in = MODE_CHR_ESC;
                  end else begin
                     char_value_in = b;
                     mode_in       = MODE_CHR_END;
                  end
               end
               MODE_CHR_ESC: begin
                  if (chr_esc_ok) begin
                     char_value_in = esc_val;
                     mode_in       = MODE_CHR_END;
                  end else begin
                     mode_in = MODE_IDLE;
                  end
               end
               MODE_CHR_END: begin
                  mode_in = MODE_IDLE;
               end
               default: begin
                  take_idle = 1'b1;
               end
            endcase
            // A byte that closes a token is lexed again from idle.
            if (take_idle) begin
               mode_in = idle.mode;
               case (idle.mode)
                  MODE_ID: begin
                     text_length_in  = 8'd1;
                     keyword_mask_in = idle.mask;
                  end
                  MODE_NUM: number_acc_in  = {24'd0, b - 8'h30};
                  MODE_OP:  pending_op_in  = b;
                  MODE_STR: text_length_in = 8'd0;
                  default:  ;
               endcase
            end
         end
      end
   end

   // Results of the accepted beat.
   always_comb begin
      res0  = mk_res(KIND_TEXT, TOK_ID, 32'd0, ERR_NONE);
      res1  = mk_res(KIND_TEXT, TOK_ID, 32'd0, ERR_NONE);
      n_res = 2'd0;
      if (req_payload.at_end) begin
         res1  = mk_res(KIND_END, TOK_NONE, 32'd0, ERR_NONE);
         n_res = 2'd2;
         case (mode_ff)
            MODE_ID: res0 = mk_res(KIND_TOKEN, kw_code(keyword_mask_ff, text_length_ff),
                                   {24'd0, text_length_ff}, ERR_NONE);
            MODE_NUM: res0 = mk_res(KIND_TOKEN, TOK_CONST, number_acc_ff, ERR_NONE);
            MODE_OP: res0 = mk_res(KIND_TOKEN, single_code(pending_op_ff), 32'd0, ERR_NONE);
            MODE_STR, MODE_STR_ESC, MODE_CHR, MODE_CHR_ESC, MODE_CHR_END:
               res0 = mk_res(KIND_ERROR, TOK_NONE, 32'd0, ERR_MISSING_QUOTE);
            default: begin
               res0  = mk_res(KIND_END, TOK_NONE, 32'd0, ERR_NONE);
               n_res = 2'd1;
            end
         endcase
      end else begin
         case (mode_ff)
            MODE_HASH: n_res = 2'd0;
            MODE_ID: begin
               if (is_id_char(b)) begin
                  res0  = mk_res(KIND_TEXT, TOK_ID, {24'd0, b}, ERR_NONE);
                  res1  = mk_res(KIND_TOKEN, kw_code(id_mask_upd, tl_inc),
                                 {24'd0, tl_inc}, ERR_NONE);
                  n_res = tl_full ? 2'd2 : 2'd1;
               end else begin
                  res0  = mk_res(KIND_TOKEN, kw_code(keyword_mask_ff, text_length_ff),
                                 {24'd0, text_length_ff}, ERR_NONE);
                  res1  = idle.res;
                  n_res = idle.emit ? 2'd2 : 2'd1;
               end
            end
            MODE_NUM: begin
               if (!is_digit(b)) begin
                  res0  = mk_res(KIND_TOKEN, TOK_CONST, number_acc_ff, ERR_NONE);
                  res1  = idle.res;
                  n_res = idle.emit ? 2'd2 : 2'd1;
               end
            end
            MODE_OP: begin
               if (dbl_code != TOK_NONE) begin
                  res0  = mk_res(KIND_TOKEN, dbl_code, 32'd0, ERR_NONE);
                  n_res = 2'd1;
               end else begin
                  res0  = mk_res(KIND_TOKEN, single_code(pending_op_ff), 32'd0, ERR_NONE);
                  res1  = idle.res;
                  n_res = idle.emit ? 2'd2 : 2'd1;
               end
            end
            MODE_STR: begin
               if (b == "\"") begin
                  res0  = mk_res(KIND_TOKEN, TOK_STRING, {24'd0, text_length_ff}, ERR_NONE);
                  n_res = 2'd1;
               end else if (b != "\\") begin
                  res0  = mk_res(KIND_TEXT, TOK_STRING, {24'd0, b}, ERR_NONE);
                  res1  = mk_res(KIND_TOKEN, TOK_STRING, {24'd0, tl_inc}, ERR_NONE);
                  n_res = tl_full ? 2'd2 : 2'd1;
               end
            end
            MODE_STR_ESC: begin
               if (str_esc_ok) begin
                  res0  = mk_res(KIND_TEXT, TOK_STRING, {24'd0, esc_val}, ERR_NONE);
                  res1  = mk_res(KIND_TOKEN, TOK_STRING, {24'd0, tl_inc}, ERR_NONE);
                  n_res = tl_full ? 2'd2 : 2'd1;
               end else begin
                  res0  = mk_res(KIND_ERROR, TOK_NONE, 32'd0, ERR_BAD_STR_ESC);
                  n_res = 2'd1;
               end
            end
            MODE_CHR: n_res = 2'd0;
            MODE_CHR_ESC: begin
               if (!chr_esc_ok) begin
                  res0  = mk_res(KIND_ERROR, TOK_NONE, 32'd0, ERR_BAD_CHR_ESC);
                  n_res = 2'd1;
               end
            end
            MODE_CHR_END: begin
               if (b == "'") begin
                  res0 = mk_res(KIND_TOKEN, TOK_CONST, {24'd0, char_value_ff}, ERR_NONE);
               end else begin
                  res0 = mk_res(KIND_ERROR, TOK_NONE, 32'd0, ERR_MISSING_QUOTE);
               end
               n_res = 2'd1;
            end
            default: begin
               res0  = idle.res;
               n_res = idle.emit ? 2'd1 : 2'd0;
            end
         endcase
      end
      res0.last = (n_res == 2'd1);
      res1.last = (n_res == 2'd2);
   end

   assign push.count = accept ? n_res : 2'd0;
   assign push.beat0 = res0;
   assign push.beat1 = res1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_IDLE;
         text_length_ff  <= 8'd0;
         keyword_mask_ff <= 8'hFF;
         number_acc_ff   <= 32'd0;
         pending_op_ff   <= 8'd0;
         char_value_ff   <= 8'd0;
      end else begin
         mode_ff         <= mode_in;
         text_length_ff  <= text_length_in;
         keyword_mask_ff <= keyword_mask_in;
         number_acc_ff   <= number_acc_in;
         pending_op_ff   <= pending_op_in;
         char_value_ff   <= char_value_in;
      end
   end

`ifndef SYNTHESIS
   // An end beat always closes with the end result.
   assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.at_end |->
         (push.count == 2'd1 && push.beat0.kind == KIND_END) ||
         (push.count == 2'd2 && push.beat1.kind == KIND_END))
      else $error("end beat without end result");

   assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.at_end |=> mode_ff == MODE_IDLE)
      else $error("lexer not idle after end of input");

   // An open identifier always holds text, and never as much as the limit.
   assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_ID |-> text_length_ff != 8'd0 && text_length_ff < MAX_TEXT)
      else $error("identifier length out of range");
`endif

endmodule

`default_nettype wire

### hw/rtl/ctok_rsp_queue.sv
`default_nettype none

module ctok_rsp_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ctok_pkg::rsp_push_type push,
   output logic                       room,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output ctok_pkg::rsp_type          rsp_payload
);
   import ctok_pkg::*;

   rsp_type                mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   head_ff, head_in;
   logic [RSP_PTR_W-1:0]   tail_ff, tail_in;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;
   logic                   pop;

   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = mem_ff[head_ff];
   assign pop         = rsp_valid && rsp_ready;
   // Room for the largest burst one beat can cause.
   assign room        = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2));

   assign head_in  = head_ff + RSP_PTR_W'(pop);
   assign tail_in  = tail_ff + RSP_PTR_W'(push.count);
   assign count_in = count_ff + RSP_CNT_W'(push.count) - RSP_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) mem_ff[tail_ff] <= push.beat0;
      if (push.count == 2'd2) mem_ff[tail_ff + RSP_PTR_W'(1)] <= push.beat1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      RSP_CNT_W'(push.count) + count_ff <= RSP_CNT_W'(RSP_DEPTH))
      else $error("result queue overflow");

   assert property (@(posedge clock) disable iff (reset)
      pop && push.count == 2'd0 |=> count_ff == $past(count_ff) - RSP_CNT_W'(1))
      else $error("result queue count lost a pop");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire

### sim/tb_c_subset_tokenizer.sv
`timescale 1ns / 100ps

module tb_c_subset_tokenizer;
   import ctok_pkg::*;

   localparam logic [4:0] TOK_SINGLE_BASE = 5'd17;
   localparam int HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int ITEMS_PER_PHASE = 355;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   c_subset_tokenizer uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Lexer state as the predictor tracks it.
   mode_type    lex_mode = MODE_IDLE;
   logic [7:0]  text_len = '0;
   logic [7:0]  kw_mask = 8'hFF;
   logic [31:0] num_acc = '0;
   logic [7:0]  op_char = '0;
   logic [7:0]  chr_val = '0;

   string   singles = ";(){}-+*,<>!=|&";
   string   separators = ";(){}-+*,";
   string   op_starts = "<>!=|&";

   req_type src_items[$];
   rsp_type beat_results[$];
   rsp_type expected_rsp[$];
   rsp_type next_rsp;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int holds_asked = 0;
   int holds_done = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int mismatches = 0;

   function automatic string kw_name(int k);
      case (k)
         0: return "int";
         1: return "char";
         2: return "if";
         3: return "else";
         4: return "for";
         5: return "while";
         6: return "return";
         default: return "sizeof";
      endcase
   endfunction

   function automatic bit letter(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction

   function automatic bit digit_char(logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic void put_rsp(logic [1:0] kind, logic [4:0] tok, logic [31:0] val,
                                   logic [2:0] err);
      rsp_type r;
      r.kind       = kind;
      r.token      = tok;
      r.value      = val;
      r.error_code = err;
      r.last       = 1'b0;
      if (beat_results.size() < 2) begin
         beat_results.push_back(r);
      end
   endfunction

   function automatic void put_single(logic [7:0] b);
      int i;
      for (i = 0; i < singles.len(); i++) begin
         if (singles[i] == b) begin
            put_rsp(KIND_TOKEN, TOK_SINGLE_BASE + 5'(i), 32'd0, ERR_NONE);
         end
      end
   endfunction

   function automatic void close_name();
      logic [4:0] code;
      bit         found;
      int         k;
      string      word;
      code  = TOK_ID;
      found = 1'b0;
      for (k = 0; k < 8; k++) begin
         word = kw_name(k);
         if (!found && kw_mask[k] && word.len() == text_len) begin
            code  = TOK_KW_BASE + 5'(k);
            found = 1'b1;
         end
      end
      put_rsp(KIND_TOKEN, code, {24'd0, text_len}, ERR_NONE);
      lex_mode = MODE_IDLE;
   endfunction

   function automatic void add_name(logic [7:0] b);
      int    k;
      string word;
      // A keyword survives only while every position so far matches it.
      for (k = 0; k < 8; k++) begin
         word = kw_name(k);
         if (text_len >= word.len() || word[text_len] != b) begin
            kw_mask[k] = 1'b0;
         end
      end
      put_rsp(KIND_TEXT, TOK_ID, {24'd0, b}, ERR_NONE);
      text_len++;
      if (text_len >= MAX_TEXT) begin
         close_name();
      end
   endfunction

   function automatic void add_str(logic [7:0] b);
      put_rsp(KIND_TEXT, TOK_STRING, {24'd0, b}, ERR_NONE);
      text_len++;
      if (text_len >= MAX_TEXT) begin
         put_rsp(KIND_TOKEN, TOK_STRING, {24'd0, text_len}, ERR_NONE);
         lex_mode = MODE_IDLE;
      end
   endfunction

   function automatic void lex_error(logic [2:0] code);
      put_rsp(KIND_ERROR, TOK_NONE, 32'd0, code);
      lex_mode = MODE_IDLE;
   endfunction

   function automatic void lex_idle(logic [7:0] b);
      lex_mode = MODE_IDLE;
      if (b == " " || (b >= 8'd9 && b <= 8'd13)) begin
         return;
      end
      if (letter(b) || b == "_") begin
         lex_mode = MODE_ID;
         text_len = '0;
         kw_mask  = 8'hFF;
         add_name(b);
      end else if (digit_char(b)) begin
         lex_mode = MODE_NUM;
         num_acc  = {24'd0, b - 8'h30};
      end else if (b == "'") begin
         lex_mode = MODE_CHR;
      end else if (b == "\"") begin
         lex_mode = MODE_STR;
         text_len = '0;
      end else if (b == "#") begin
         lex_mode = MODE_HASH;
      end else if (b == "<" || b == ">" || b == "!" || b == "=" || b == "|" || b == "&") begin
         lex_mode = MODE_OP;
         op_char  = b;
      end else if (b == ";" || b == "(" || b == ")" || b == "{" || b == "}" ||
                   b == "-" || b == "+" || b == "*" || b == ",") begin
         put_single(b);
      end else if (b >= 8'd33 && b <= 8'd126) begin
         lex_error(ERR_BAD_PUNCT);
      end else begin
         lex_error(ERR_BAD_CHAR);
      end
   endfunction

   function automatic void lex_pair(logic [7:0] b);
      logic [4:0] code;
      code = TOK_NONE;
      if (b == "=") begin
         if (op_char == "<") code = TOK_LE;
         else if (op_char == ">") code = TOK_GE;
         else if (op_char == "!") code = TOK_NE;
         else if (op_char == "=") code = TOK_EQ;
      end else if (b == "|" && op_char == "|") begin
         code = TOK_OROR;
      end else if (b == "&" && op_char == "&") begin
         code = TOK_ANDAND;
      end
      if (code != TOK_NONE) begin
         put_rsp(KIND_TOKEN, code, 32'd0, ERR_NONE);
         lex_mode = MODE_IDLE;
      end else begin
         put_single(op_char);
         lex_idle(b);
      end
   endfunction

   function automatic void lex_end();
      case (lex_mode)
         MODE_ID: close_name();
         MODE_NUM: put_rsp(KIND_TOKEN, TOK_CONST, num_acc, ERR_NONE);
         MODE_OP: put_single(op_char);
         MODE_STR, MODE_STR_ESC, MODE_CHR, MODE_CHR_ESC, MODE_CHR_END:
            put_rsp(KIND_ERROR, TOK_NONE, 32'd0, ERR_MISSING_QUOTE);
         default: ;
      endcase
      lex_mode = MODE_IDLE;
      put_rsp(KIND_END, TOK_NONE, 32'd0, ERR_NONE);
   endfunction

   // Work out the results of one accepted beat and queue them.
   function automatic void predict_beat(req_type item);
      logic [7:0] b;
      rsp_type    r;
      b = item.byte_req;
      beat_results.delete();
      if (item.at_end) begin
         lex_end();
      end else begin
         case (lex_mode)
            MODE_HASH: begin
               if (b == "\n") lex_mode = MODE_IDLE;
            end
            MODE_ID: begin
               if (letter(b) || digit_char(b) || b == "_") begin
                  add_name(b);
               end else begin
                  close_name();
                  lex_idle(b);
               end
            end
            MODE_NUM: begin
               if (digit_char(b)) begin
                  num_acc = num_acc * 32'd10 + {24'd0, b - 8'h30};
               end else begin
                  put_rsp(KIND_TOKEN, TOK_CONST, num_acc, ERR_NONE);
                  lex_idle(b);
               end
            end
            MODE_OP: lex_pair(b);
            MODE_STR: begin
               if (b == "\"") begin
                  put_rsp(KIND_TOKEN, TOK_STRING, {24'd0, text_len}, ERR_NONE);
                  lex_mode = MODE_IDLE;
               end else if (b == "\\") begin
                  lex_mode = MODE_STR_ESC;
               end else begin
                  add_str(b);
               end
            end
            MODE_STR_ESC: begin
               lex_mode = MODE_STR;
               if (b == "n") add_str(8'h0A);
               else if (b == "t") add_str(8'h09);
               else if (b == "\\" || b == "\"") add_str(b);
               else lex_error(ERR_BAD_STR_ESC);
            end
            MODE_CHR: begin
               if (b == "\\") begin
                  lex_mode = MODE_CHR_ESC;
               end else begin
                  chr_val  = b;
                  lex_mode = MODE_CHR_END;
               end
            end
            MODE_CHR_ESC: begin
               lex_mode = MODE_CHR_END;
               if (b == "n") chr_val = 8'h0A;
               else if (b == "t") chr_val = 8'h09;
               else if (b == "\\" || b == "'") chr_val = b;
               else lex_error(ERR_BAD_CHR_ESC);
            end
            MODE_CHR_END: begin
               if (b == "'") begin
                  put_rsp(KIND_TOKEN, TOK_CONST, {24'd0, chr_val}, ERR_NONE);
                  lex_mode = MODE_IDLE;
               end else begin
                  lex_error(ERR_MISSING_QUOTE);
               end
            end
            default: lex_idle(b);
         endcase
      end
      if (beat_results.size() > 0) begin
         r = beat_results.pop_back();
         r.last = 1'b1;
         beat_results.push_back(r);
      end
      while (beat_results.size() > 0) begin
         expected_rsp.push_back(beat_results.pop_front());
      end
   endfunction

   // Source side: a beat stays on the port until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_beat(req_payload);
         end
         if (!req_valid || req_ready) begin
            if (src_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid   <= 1'b1;
               req_payload <= src_items.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result side: check each beat and decide on back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $error("result with nothing expected: kind %0d token %0d value %0h",
                      rsp_payload.kind, rsp_payload.token, rsp_payload.value);
               mismatches++;
            end else begin
               next_rsp = expected_rsp.pop_front();
               if (rsp_payload.kind !== next_rsp.kind) begin
                  $error("kind: expected %0d, got %0d", next_rsp.kind, rsp_payload.kind);
                  mismatches++;
               end
               if (rsp_payload.token !== next_rsp.token) begin
                  $error("token: expected %0d, got %0d", next_rsp.token, rsp_payload.token);
                  mismatches++;
               end
               if (rsp_payload.value !== next_rsp.value) begin
                  $error("value: expected %0h, got %0h", next_rsp.value, rsp_payload.value);
                  mismatches++;
               end
               if (rsp_payload.error_code !== next_rsp.error_code) begin
                  $error("error_code: expected %0d, got %0d", next_rsp.error_code,
                         rsp_payload.error_code);
                  mismatches++;
               end
               if (rsp_payload.last !== next_rsp.last) begin
                  $error("last: expected %0d, got %0d", next_rsp.last, rsp_payload.last);
                  mismatches++;
               end
            end
         end
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (holds_done != holds_asked) begin
            // Long hold-off so the result queue fills and the source stalls.
            holds_done <= holds_done + 1;
            hold_left  <= HOLD_CYCLES;
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_byte(logic [7:0] b);
      req_type item;
      item.byte_req = b;
      item.at_end   = 1'b0;
      src_items.push_back(item);
   endtask

   task automatic push_end(logic [7:0] b);
      req_type item;
      item.byte_req = b;
      item.at_end   = 1'b1;
      src_items.push_back(item);
   endtask

   task automatic push_text(string s);
      int i;
      for (i = 0; i < s.len(); i++) begin
         push_byte(s[i]);
      end
   endtask

   function automatic logic [7:0] name_byte(bit lead);
      int r;
      r = lead ? $urandom_range(52) : $urandom_range(63);
      if (r < 26) return 8'("a" + r);
      else if (r < 52) return 8'("A" + r - 26);
      else if (r < 62 && !lead) return 8'("0" + r - 52);
      else return "_";
   endfunction

   // One lexical fragment, mostly well formed, sometimes noise or broken.
   task automatic add_fragment();
      int         pick, sel, len, i;
      logic [7:0] b;
      string      word;
      pick = $urandom_range(99);
      if (pick < 22) begin
         sel = $urandom_range(9);
         if (sel < 4) begin
            word = kw_name($urandom_range(7));
            push_text(word);
         end else if (sel == 4) begin
            word = kw_name($urandom_range(7));
            len  = $urandom_range(word.len() - 1, 1);
            push_text(word.substr(0, len - 1));
         end else if (sel == 5) begin
            word = kw_name($urandom_range(7));
            push_text(word);
            push_byte(name_byte(1'b0));
         end else begin
            len = ($urandom_range(24) == 0) ? $urandom_range(135, 120) : $urandom_range(8, 1);
            push_byte(name_byte(1'b1));
            for (i = 1; i < len; i++) begin
               push_byte(name_byte(1'b0));
            end
         end
      end else if (pick < 32) begin
         len = $urandom_range(12, 1);
         for (i = 0; i < len; i++) begin
            push_byte(8'("0" + $urandom_range(9)));
         end
      end else if (pick < 42) begin
         push_byte("'");
         sel = $urandom_range(99);
         if (sel < 60) begin
            push_byte(8'($urandom_range(255)));
            push_byte("'");
         end else if (sel < 85) begin
            push_byte("\\");
            case ($urandom_range(3))
               0: push_byte("n");
               1: push_byte("t");
               2: push_byte("\\");
               default: push_byte("'");
            endcase
            push_byte("'");
         end else if (sel < 93) begin
            b = 8'($urandom_range(255));
            if (b == "n" || b == "t" || b == "\\" || b == "'") b = "q";
            push_byte("\\");
            push_byte(b);
         end else begin
            b = 8'($urandom_range(255));
            if (b == "'") b = "z";
            push_byte(8'($urandom_range(255)));
            push_byte(b);
         end
      end else if (pick < 52) begin
         push_byte("\"");
         len = ($urandom_range(24) == 0) ? $urandom_range(135, 120) : $urandom_range(10);
         for (i = 0; i < len; i++) begin
            sel = $urandom_range(99);
            if (sel < 15) begin
               push_byte("\\");
               case ($urandom_range(3))
                  0: push_byte("n");
                  1: push_byte("t");
                  2: push_byte("\\");
                  default: push_byte("\"");
               endcase
            end else if (sel < 17) begin
               b = 8'($urandom_range(255));
               if (b == "n" || b == "t" || b == "\\" || b == "\"") b = "a";
               push_byte("\\");
               push_byte(b);
            end else begin
               b = 8'($urandom_range(255));
               if (b == "\"" || b == "\\") b = "x";
               push_byte(b);
            end
         end
         push_byte("\"");
      end else if (pick < 70) begin
         b = op_starts[$urandom_range(5)];
         push_byte(b);
         sel = $urandom_range(2);
         if (sel == 0) begin
            push_byte("=");
         end else if (sel == 1) begin
            push_byte(b);
         end
      end else if (pick < 78) begin
         len = $urandom_range(3, 1);
         for (i = 0; i < len; i++) begin
            sel = $urandom_range(5);
            push_byte(sel == 0 ? " " : 8'(8 + sel));
         end
      end else if (pick < 82) begin
         push_byte("#");
         len = $urandom_range(6);
         for (i = 0; i < len; i++) begin
            b = 8'($urandom_range(255));
            if (b == "\n") b = "x";
            push_byte(b);
         end
         push_byte("\n");
      end else if (pick < 88) begin
         push_byte(separators[$urandom_range(8)]);
      end else if (pick < 94) begin
         push_byte(8'($urandom_range(255)));
      end else if (pick < 97) begin
         push_end(8'($urandom_range(255)));
      end else begin
         push_byte(8'($urandom_range(126, 33)));
      end
      if ($urandom_range(9) < 3) begin
         push_byte(" ");
      end
   endtask

   task automatic wait_drained();
      while (src_items.size() != 0 || req_valid || expected_rsp.size() != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      int phase;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 58; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 58; end
            default: begin send_idle_pct = 29; recv_stall_pct = 29; end
         endcase
         if (phase == 0) begin
            push_text("#x\n");
            push_text("a1=");
            push_text("=");
            push_text("'\\q");
            push_text("'ab");
            push_byte(8'hFF);
            push_byte(8'h00);
            push_text("\"\\z");
            push_text("\"a");
            push_end(8'hFF);
            push_end(8'h00);
            push_text("9<");
            push_end(8'($urandom_range(255)));
         end
         while (src_items.size() < ITEMS_PER_PHASE) begin
            add_fragment();
         end
         if (phase == 0) begin
            holds_asked++;
         end
         // The source pauses here until every result of the phase is back.
         wait_drained();
      end
      repeat (10) @(negedge clock);
      if (expected_rsp.size() != 0) begin
         $error("%0d results never arrived", expected_rsp.size());
      end
      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/ctok_pkg.sv
hw/rtl/ctok_lexer.sv
hw/rtl/ctok_rsp_queue.sv
hw/rtl/c_subset_tokenizer.sv
sim/tb_c_subset_tokenizer.sv
